>>> rtl/core/ilp_pkg.sv
// shared constants and types for the integer literal parser
`default_nettype none

package ilp_pkg;

	// datapath sizing
	localparam int VALUE_BITS    = 64;
	localparam int POSITION_BITS = 16;
	localparam int OUT_BITS      = 64;
	localparam int LEN_BITS      = 16;

	// depth of the class queue and of the result queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// one classified character, as handed from the front to the back
	typedef struct packed {
		logic       fin;
		logic       white;
		logic       plus;
		logic       minus;
		logic       zero;
		logic       dec_ok;
		logic       hex_ok;
		logic       bin_ok;
		logic       hex_mark;
		logic       bin_mark;
		logic [3:0] digit;
	} ilp_class_t;

	// one finished number waiting in the result queue
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  neg;
		logic [LEN_BITS-1:0]   len;
		logic                  found;
	} ilp_result_t;

endpackage

`default_nettype wire

>>> rtl/core/integer_literal_parser_top.sv
// top level of the integer literal parser
`default_nettype none

// Streaming integer literal parser. Characters enter one per cycle through
// push/full; each is classified and placed in a two-entry class queue, and the
// parse engine takes one class per cycle while a result slot is free, updating
// a shift-and-add accumulator (times 10, 16 or 2). Leading whitespace and one
// sign are skipped, a 0x or 0b prefix selects hex or binary, and the first
// non-digit ends the number. When the character flagged as final is processed,
// one result (value, consumed length, found flag) enters a two-entry result
// queue read through empty/pop. Sustained rate is one character per cycle,
// set by the accumulator update, while results can be queued; a final
// character is registered in the class queue and its result in the result
// queue before it reaches the outputs. A full result queue halts the engine.
module integer_literal_parser_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	output logic                                 full,
	input  wire logic [7:0]                      char_code,
	input  wire logic                            final_char,
	output logic                                 empty,
	input  wire logic                            pop,
	output logic signed [ilp_pkg::OUT_BITS-1:0]  parsed_value,
	output logic [ilp_pkg::LEN_BITS-1:0]         consumed_length,
	output logic                                 number_found
);
	import ilp_pkg::*;

	ilp_class_t cls_data;
	logic       cls_empty;
	logic       cls_pop;

	// character classification and class queue
	ilp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_code  (char_code),
		.final_char (final_char),
		.cls_data   (cls_data),
		.cls_empty  (cls_empty),
		.cls_pop    (cls_pop)
	);

	// parse engine and result queue
	ilp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cls_data        (cls_data),
		.cls_empty       (cls_empty),
		.cls_pop         (cls_pop),
		.empty           (empty),
		.pop             (pop),
		.parsed_value    (parsed_value),
		.consumed_length (consumed_length),
		.number_found    (number_found)
	);

endmodule

`default_nettype wire

>>> rtl/core/ilp_front.sv
// front end: takes characters, classifies them and queues the classes
`default_nettype none

module ilp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [7:0]         char_code,
	input  wire logic               final_char,
	output ilp_pkg::ilp_class_t     cls_data,
	output logic                    cls_empty,
	input  wire logic               cls_pop
);
	import ilp_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_ONE   = 8'd49;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_F  = 8'd70;
	localparam logic [7:0] CH_LO_A  = 8'd97;
	localparam logic [7:0] CH_LO_F  = 8'd102;
	localparam logic [7:0] CH_UP_X  = 8'd88;
	localparam logic [7:0] CH_LO_X  = 8'd120;
	localparam logic [7:0] CH_UP_B  = 8'd66;
	localparam logic [7:0] CH_LO_B  = 8'd98;

	ilp_class_t              cls_in;
	logic                    is_letter;
	logic                    wr_en;
	logic                    rd_en;
	ilp_class_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_CW-1:0]     cnt_q;

	// character classification
	always_comb begin
		is_letter       = ((char_code >= CH_LO_A) && (char_code <= CH_LO_F)) ||
		                  ((char_code >= CH_UP_A) && (char_code <= CH_UP_F));
		cls_in.fin      = final_char;
		cls_in.white    = (char_code == CH_SPACE) ||
		                  ((char_code >= CH_TAB) && (char_code <= CH_CR));
		cls_in.plus     = (char_code == CH_PLUS);
		cls_in.minus    = (char_code == CH_MINUS);
		cls_in.zero     = (char_code == CH_ZERO);
		cls_in.dec_ok   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		cls_in.hex_ok   = cls_in.dec_ok || is_letter;
		cls_in.bin_ok   = (char_code == CH_ZERO) || (char_code == CH_ONE);
		cls_in.hex_mark = (char_code == CH_LO_X) || (char_code == CH_UP_X);
		cls_in.bin_mark = (char_code == CH_LO_B) || (char_code == CH_UP_B);
		// letters a-f and A-F both have low nibble 1..6
		cls_in.digit    = is_letter ? (char_code[3:0] + 4'd9) : char_code[3:0];
	end

	// class queue control
	assign full      = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign cls_empty = (cnt_q == '0);
	assign wr_en     = push && !full;
	assign rd_en     = cls_pop && !cls_empty;
	assign cls_data  = slot_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= cls_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + QUEUE_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + QUEUE_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + QUEUE_CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - QUEUE_CW'(1);
			end
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("class queue over depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + QUEUE_CW'(1)))
		else $error("class queue count missed a write");

	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> (cnt_q == $past(cnt_q) - QUEUE_CW'(1)))
		else $error("class queue count missed a read");

endmodule

`default_nettype wire

>>> rtl/core/ilp_back.sv
// back end: parse state machine, accumulator and result queue
`default_nettype none

module ilp_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ilp_pkg::ilp_class_t       cls_data,
	input  wire logic                      cls_empty,
	output logic                           cls_pop,
	output logic                           empty,
	input  wire logic                      pop,
	output logic signed [ilp_pkg::OUT_BITS-1:0] parsed_value,
	output logic [ilp_pkg::LEN_BITS-1:0]   consumed_length,
	output logic                           number_found
);
	import ilp_pkg::*;

	// parse phases
	localparam logic [2:0] PH_WHITE  = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_DEC    = 3'd3;
	localparam logic [2:0] PH_HEX    = 3'd4;
	localparam logic [2:0] PH_BIN    = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	localparam int LEN_EXT = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [2:0]               phase_q, phase_d;
	logic                     neg_q, neg_d;
	logic [VALUE_BITS-1:0]    acc_q, acc_d;
	logic [POSITION_BITS-1:0] pos_q, pos_next;
	logic [POSITION_BITS-1:0] end_q, end_d;
	logic                     seen_q, seen_d;

	logic                     take;
	logic                     res_full;
	logic                     res_wr;
	logic                     res_rd;
	logic                     take_digit;
	logic [VALUE_BITS-1:0]    acc_dec;
	logic [VALUE_BITS-1:0]    acc_hex;
	logic [VALUE_BITS-1:0]    acc_bin;
	logic [LEN_EXT-1:0]       end_ext;
	ilp_result_t              res_in;
	ilp_result_t              res_head;
	logic [VALUE_BITS-1:0]    mag;

	ilp_result_t              res_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]      wr_ptr_q;
	logic [QUEUE_AW-1:0]      rd_ptr_q;
	logic [QUEUE_CW-1:0]      cnt_q;

	// a class is taken whenever one is waiting and a result slot is free
	assign res_full = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign take     = !cls_empty && !res_full;
	assign cls_pop  = !res_full;
	assign res_wr   = take && cls_data.fin;

	// shift-and-add candidates for each base
	assign acc_dec = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(cls_data.digit);
	assign acc_hex = (acc_q << 4) | VALUE_BITS'(cls_data.digit);
	assign acc_bin = (acc_q << 1) | VALUE_BITS'(cls_data.digit[0]);

	// saturating position count
	assign pos_next = (pos_q != POS_MAX) ? pos_q + POSITION_BITS'(1) : pos_q;

	// next state of the parser
	always_comb begin
		phase_d    = phase_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		end_d      = end_q;
		seen_d     = seen_q;
		take_digit = 1'b0;
		case (phase_q)
			PH_WHITE, PH_SIGNED: begin
				if ((phase_q == PH_WHITE) && cls_data.white) begin
					phase_d = PH_WHITE;
				end else if ((phase_q == PH_WHITE) && (cls_data.plus || cls_data.minus)) begin
					neg_d   = cls_data.minus;
					phase_d = PH_SIGNED;
				end else if (cls_data.zero) begin
					acc_d      = acc_dec;
					take_digit = 1'b1;
					phase_d    = PH_ZERO;
				end else if (cls_data.dec_ok) begin
					acc_d      = acc_dec;
					take_digit = 1'b1;
					phase_d    = PH_DEC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_ZERO: begin
				if (cls_data.hex_mark || cls_data.bin_mark) begin
					acc_d   = '0;
					seen_d  = 1'b0;
					end_d   = '0;
					phase_d = cls_data.hex_mark ? PH_HEX : PH_BIN;
				end else if (cls_data.dec_ok) begin
					acc_d      = acc_dec;
					take_digit = 1'b1;
					phase_d    = PH_DEC;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_DEC: begin
				if (cls_data.dec_ok) begin
					acc_d      = acc_dec;
					take_digit = 1'b1;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_HEX: begin
				if (cls_data.hex_ok) begin
					acc_d      = acc_hex;
					take_digit = 1'b1;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_BIN: begin
				if (cls_data.bin_ok) begin
					acc_d      = acc_bin;
					take_digit = 1'b1;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		if (take_digit) begin
			seen_d = 1'b1;
			end_d  = pos_next;
		end
	end

	// result built from the state after the final character
	always_comb begin
		end_ext      = LEN_EXT'(end_d);
		res_in.value = seen_d ? acc_d : '0;
		res_in.neg   = neg_d;
		res_in.found = seen_d;
		if (!seen_d) begin
			res_in.len = '0;
		end else if (end_ext > LEN_EXT'(LEN_MAX)) begin
			res_in.len = LEN_MAX;
		end else begin
			res_in.len = end_ext[LEN_BITS-1:0];
		end
	end

	// parser state, back to its start after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WHITE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			pos_q   <= '0;
			end_q   <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (cls_data.fin) begin
				phase_q <= PH_WHITE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				pos_q   <= '0;
				end_q   <= '0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
				pos_q   <= pos_next;
				end_q   <= end_d;
				seen_q  <= seen_d;
			end
		end
	end

	// result queue
	assign empty    = (cnt_q == '0);
	assign res_rd   = pop && !empty;
	assign res_head = res_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_wr) begin
			res_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_wr) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + QUEUE_AW'(1);
			end
			if (res_rd) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + QUEUE_AW'(1);
			end
			if (res_wr && !res_rd) begin
				cnt_q <= cnt_q + QUEUE_CW'(1);
			end else if (res_rd && !res_wr) begin
				cnt_q <= cnt_q - QUEUE_CW'(1);
			end
		end
	end

	// sign applied on the way out, then cast to the signed port width
	assign mag             = res_head.neg ? (~res_head.value + VALUE_BITS'(1)) : res_head.value;
	assign parsed_value    = OUT_BITS'($signed(mag));
	assign consumed_length = res_head.len;
	assign number_found    = res_head.found;

	// checks
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cls_data.fin) |=> (phase_q == PH_WHITE && !seen_q && pos_q == '0))
		else $error("parser did not restart after final character");

	a_seen_end: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (end_q != '0))
		else $error("digit seen but end position is zero");

	a_unseen_acc: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (acc_q == '0))
		else $error("accumulator not clear without digits");

	a_end_le_pos: assert property (@(posedge clk) disable iff (!arst_n)
		end_q <= pos_q)
		else $error("end position ahead of character position");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("result queue over depth");

endmodule

`default_nettype wire
